// ===== hdl/mhma_pkg.sv =====
// Shared constants and the arctangent table for the magnetic heading averager.
package mhma_pkg;

    localparam int WINDOW_LEN_DEF   = 20;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int MAG_W      = 16;
    localparam int S_TDATA_W  = 2 * MAG_W;
    localparam int XY_FRAC    = 16;
    localparam int XY_W       = 36;
    localparam int ZW         = 34;
    localparam int TURN_BITS  = 32;
    localparam int MAX_STEPS  = 32;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1 <<< (TURN_BITS - 2));

    localparam logic [TURN_BITS-1:0] ATAN_TURN32 [0:MAX_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ===== hdl/magnetic_heading_moving_average_top.sv =====
// Magnetic heading (CORDIC atan2) with a ring-buffer moving average.
// At the defaults the pipeline has 16 CORDIC stages and 2 divide-by-window stages.
// Throughput: one item per cycle while the output is not stalled; the ring memory does
// one read and one write per cycle, with the write forwarded to a read of the same entry.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes the running sum and slot,
// and marks every ring entry empty so it reads as zero.
module magnetic_heading_moving_average_top #(
    parameter int WINDOW_LEN   = mhma_pkg::WINDOW_LEN_DEF,
    parameter int ANGLE_BITS   = mhma_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = mhma_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [mhma_pkg::S_TDATA_W-1:0]          s_axis_tdata,  // mag_x, mag_y
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((ANGLE_BITS+7)/8)*8-1:0]         m_axis_tdata   // heading_mean
);
    import mhma_pkg::*;

    localparam int A        = ANGLE_BITS;
    localparam int W        = WINDOW_LEN;
    localparam int STEPS    = CORDIC_STEPS;
    localparam int OUT_W    = ((A + 7) / 8) * 8;
    localparam int SLOT_W   = (W > 1) ? $clog2(W) : 1;
    localparam int WL       = $clog2(W);
    localparam int SUM_W    = A + WL;
    localparam int PROD_W   = 2 * SUM_W + 1;
    localparam int SH       = TURN_BITS - A;
    localparam logic signed [ZW-1:0] HALF = (SH > 0) ? ZW'(64'sd1 <<< (SH - 1)) : '0;
    localparam logic signed [ZW-1:0] HI   = ZW'((64'sd1 <<< (A - 1)) - 1);
    localparam logic signed [ZW-1:0] LO   = ZW'(-(64'sd1 <<< (A - 1)));
    localparam logic [SLOT_W-1:0]    SLOT_LAST = SLOT_W'(W - 1);
    localparam logic [SUM_W:0]       RECIP     =
        (SUM_W + 1)'(((64'd1 << (SUM_W + WL)) + 64'(W - 1)) / 64'(W));

    logic adv;

    // CORDIC pipeline
    logic signed [XY_W-1:0] cx_reg [0:STEPS];
    logic signed [XY_W-1:0] cy_reg [0:STEPS];
    logic signed [ZW-1:0]   cz_reg [0:STEPS];
    logic                   czero_reg [0:STEPS];
    logic                   cv_reg [0:STEPS];
    logic signed [XY_W-1:0] cx_next [0:STEPS-1];
    logic signed [XY_W-1:0] cy_next [0:STEPS-1];
    logic signed [ZW-1:0]   cz_next [0:STEPS-1];

    logic signed [MAG_W-1:0] in_mag_x;
    logic signed [MAG_W-1:0] in_mag_y;
    logic signed [XY_W-1:0]  mx_ext;
    logic signed [XY_W-1:0]  my_ext;
    logic signed [XY_W-1:0]  x0_next;
    logic signed [XY_W-1:0]  y0_next;
    logic signed [ZW-1:0]    z0_next;

    // heading, ring access, sum
    logic signed [ZW-1:0]   zr;
    logic signed [ZW-1:0]   zs;
    logic signed [A-1:0]    h_next;
    logic signed [A-1:0]    h_reg;
    logic                   hv_reg;
    logic signed [A-1:0]    hq_reg;
    logic [SLOT_W-1:0]      wslot_reg;
    logic                   qv_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic signed [A-1:0]    ring_mem [0:W-1];
    logic                   entry_valid_reg [0:W-1];
    logic signed [A-1:0]    rd_reg;
    logic                   rdv_reg;
    logic signed [A-1:0]    old_val;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                   sumv_reg;

    // divide-by-window pipeline
    logic [SUM_W-1:0]  sum_mag;
    logic [SUM_W-1:0]  mag_reg;
    logic              mneg_reg;
    logic              mv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              pneg_reg;
    logic              pv_reg;
    logic [A-1:0]      quo_a;
    logic [A-1:0]      out_next;

    logic             out_valid_reg;
    logic [A-1:0]     out_data_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    // pre-rotation by a quarter turn, operands a = -mag_y, b = -mag_x
    always_comb begin
        in_mag_x = s_axis_tdata[MAG_W-1:0];
        in_mag_y = s_axis_tdata[2*MAG_W-1:MAG_W];
        mx_ext   = XY_W'(in_mag_x);
        my_ext   = XY_W'(in_mag_y);
        if (mx_ext <= 0) begin
            x0_next = (-mx_ext) <<< XY_FRAC;
            y0_next = my_ext <<< XY_FRAC;
            z0_next = QUARTER_TURN;
        end else begin
            x0_next = mx_ext <<< XY_FRAC;
            y0_next = (-my_ext) <<< XY_FRAC;
            z0_next = -QUARTER_TURN;
        end
    end

    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            if (cy_reg[k] > 0) begin
                cx_next[k] = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next[k] = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next[k] = cz_reg[k] + $signed(ZW'(ATAN_TURN32[k]));
            end else begin
                cx_next[k] = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next[k] = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next[k] = cz_reg[k] - $signed(ZW'(ATAN_TURN32[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg[0]    <= x0_next;
            cy_reg[0]    <= y0_next;
            cz_reg[0]    <= z0_next;
            czero_reg[0] <= (in_mag_x == '0) && (in_mag_y == '0);
            for (int k = 0; k < STEPS; k++) begin
                cx_reg[k+1]    <= cx_next[k];
                cy_reg[k+1]    <= cy_next[k];
                cz_reg[k+1]    <= cz_next[k];
                czero_reg[k+1] <= czero_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STEPS; k++) begin
                cv_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            cv_reg[0] <= s_axis_tvalid;
            for (int k = 0; k < STEPS; k++) begin
                cv_reg[k+1] <= cv_reg[k];
            end
        end
    end

    // round half up to ANGLE_BITS and saturate; an all-zero input gives heading zero
    always_comb begin
        zr = cz_reg[STEPS] + HALF;
        zs = zr >>> SH;
        priority if (czero_reg[STEPS]) begin
            h_next = '0;
        end else if (zs > HI) begin
            h_next = HI[A-1:0];
        end else if (zs < LO) begin
            h_next = LO[A-1:0];
        end else begin
            h_next = zs[A-1:0];
        end
    end

    always_comb begin
        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        old_val   = rdv_reg ? rd_reg : '0;
        sum_next  = sum_reg - SUM_W'(old_val) + SUM_W'(hq_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_reg     <= h_next;
            hq_reg    <= h_reg;
            wslot_reg <= slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (qv_reg) begin
                ring_mem[wslot_reg] <= hq_reg;
            end
            if (qv_reg && (wslot_reg == slot_reg)) begin
                rd_reg <= hq_reg;
            end else begin
                rd_reg <= ring_mem[slot_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg   <= 1'b0;
            qv_reg   <= 1'b0;
            sumv_reg <= 1'b0;
            slot_reg <= '0;
            sum_reg  <= '0;
            rdv_reg  <= 1'b0;
            for (int i = 0; i < W; i++) begin
                entry_valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            hv_reg   <= cv_reg[STEPS];
            qv_reg   <= hv_reg;
            sumv_reg <= qv_reg;
            rdv_reg  <= (qv_reg && (wslot_reg == slot_reg)) ? 1'b1 : entry_valid_reg[slot_reg];
            if (hv_reg) begin
                slot_reg <= slot_next;
            end
            if (qv_reg) begin
                entry_valid_reg[wslot_reg] <= 1'b1;
                sum_reg                    <= sum_next;
            end
        end
    end

    // divide |sum| by the window length: multiply by the rounded-up reciprocal, keep high bits
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg  <= sum_mag;
            mneg_reg <= sum_reg[SUM_W-1];
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
            pneg_reg <= mneg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else if (adv) begin
            mv_reg <= sumv_reg;
            pv_reg <= mv_reg;
        end
    end

    always_comb begin
        quo_a    = prod_reg[SUM_W+WL +: A];
        out_next = pneg_reg ? (~quo_a + 1'b1) : quo_a;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= pv_reg;
        end
    end

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_LAST)
        else $error("ring slot beyond window");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> cv_reg[0])
        else $error("accepted item missing from first CORDIC stage");

    a_slot_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        hv_reg && adv |=> slot_reg == (($past(slot_reg) == SLOT_LAST) ?
                                       '0 : $past(slot_reg) + 1'b1))
        else $error("ring slot did not advance with item");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        qv_reg && !adv |=> qv_reg && $stable(sum_reg) && $stable(slot_reg))
        else $error("ring stage moved during stall");

endmodule

// ===== tb/tb_magnetic_heading_moving_average_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the CORDIC heading averager: directed table, random samples, predictor.
module tb_magnetic_heading_moving_average_top;

    localparam int WINDOW       = 20;
    localparam int STEPS        = 16;
    localparam int N_DIRECTED   = 24;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PCT     = 31;
    localparam int PAUSE_A      = N_DIRECTED;
    localparam int PAUSE_B      = 900;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 650;
    localparam int DRAIN_WAIT   = 40;
    localparam int LIMIT        = 200000;

    localparam longint ATAN_STEP [STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861
    };

    localparam logic [15:0] CORNERS [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};

    typedef struct {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        bit                 known;
        logic signed [15:0] mean;
    } mag_sample_t;

    mag_sample_t directed_rows [N_DIRECTED] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'sd0},
        '{16'sd0,      16'sh8000,   1'b1, 16'sd0},
        '{16'sd0,      -16'sd1,     1'b1, 16'sd0},
        '{16'sd0,      16'sd0,      1'b1, 16'sd0},
        '{16'sd0,      16'sh7FFF,   1'b0, 16'sd0},
        '{16'sd0,      16'sd1,      1'b0, 16'sd0},
        '{16'sd1,      16'sh7FFF,   1'b0, 16'sd0},
        '{-16'sd1,     16'sh7FFF,   1'b0, 16'sd0},
        '{16'sh7FFF,   16'sh7FFF,   1'b0, 16'sd0},
        '{16'sh8000,   16'sh8000,   1'b0, 16'sd0},
        '{16'sh7FFF,   16'sh8000,   1'b0, 16'sd0},
        '{16'sh8000,   16'sh7FFF,   1'b0, 16'sd0},
        '{16'sh8000,   16'sd0,      1'b0, 16'sd0},
        '{16'sh7FFF,   16'sd0,      1'b0, 16'sd0},
        '{16'sd1,      16'sd0,      1'b0, 16'sd0},
        '{-16'sd1,     16'sd0,      1'b0, 16'sd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
        '{16'sd1,      16'sd1,      1'b0, 16'sd0},
        '{16'sd1,      -16'sd1,     1'b0, 16'sd0},
        '{-16'sd1,     16'sd1,      1'b0, 16'sd0},
        '{16'sh5555,   16'shAAAA,   1'b0, 16'sd0},
        '{16'shAAAA,   16'sh5555,   1'b0, 16'sd0},
        '{16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sd123,    -16'sd4567,  1'b0, 16'sd0}
    };

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [mhma_pkg::S_TDATA_W-1:0]    s_axis_tdata  = '0;   // mag_x, mag_y
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [15:0]                       m_axis_tdata;         // heading_mean

    mag_sample_t        samples [$];
    logic signed [15:0] mean_queue [$];
    longint             heading_ring [WINDOW] = '{default: 0};
    longint             window_sum = 0;
    int                 ring_slot  = 0;
    int                 sent       = 0;
    int                 fails      = 0;
    int                 cycles     = 0;

    magnetic_heading_moving_average_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint cordic_heading(logic signed [15:0] mx, logic signed [15:0] my);
        longint a, b, x, y, z, dx, dy, r;
        a = -longint'(my);
        b = -longint'(mx);
        if (a == 0 && b == 0)
            return 0;
        if (b >= 0) begin
            x = b;
            y = -a;
            z = longint'(1) <<< 30;
        end else begin
            x = -b;
            y = a;
            z = -(longint'(1) <<< 30);
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
        end
        r = (z + 32768) >>> 16;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    always @(posedge aclk) begin : stream_bfm
        longint             head;
        logic signed [15:0] mean_now;
        bit                 calm;
        bit                 draining;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            calm = (sent >= CALM_FROM) && (sent < CALM_TO);
            if (m_axis_tvalid && m_axis_tready) begin
                if (mean_queue.size() == 0) begin
                    $error("heading_mean: expected nothing, got %0d", $signed(m_axis_tdata));
                    fails++;
                end else begin
                    mean_now = mean_queue.pop_front();
                    if (m_axis_tdata !== mean_now) begin
                        $error("heading_mean: expected %0d, got %0d",
                               mean_now, $signed(m_axis_tdata));
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                head = cordic_heading(samples[sent].mag_x, samples[sent].mag_y);
                window_sum = window_sum - heading_ring[ring_slot] + head;
                heading_ring[ring_slot] = head;
                ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
                mean_now = 16'(window_sum / WINDOW);
                mean_queue.push_back(samples[sent].known ? samples[sent].mean : mean_now);
                sent++;
            end
            draining = (sent == PAUSE_A || sent == PAUSE_B) && mean_queue.size() != 0;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sent < samples.size() && !draining
                        && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tdata  <= {samples[sent].mag_y, samples[sent].mag_x};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_magnetic_heading_moving_average_top: FAIL");
            $finish;
        end
    end

    initial begin
        mag_sample_t smp;
        for (int n = 0; n < N_DIRECTED; n++)
            samples.push_back(directed_rows[n]);
        smp = directed_rows[N_DIRECTED-1];
        smp.known = 1'b0;
        smp.mean  = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(9))
                5: begin
                    smp.mag_x = 16'($urandom_range(32) - 16);
                    smp.mag_y = 16'($urandom_range(32) - 16);
                end
                6: begin
                    if ($urandom_range(1)) begin
                        smp.mag_x = '0;
                        smp.mag_y = 16'($urandom);
                    end else begin
                        smp.mag_x = 16'($urandom);
                        smp.mag_y = '0;
                    end
                end
                7: begin
                    smp.mag_x = CORNERS[$urandom_range(4)];
                    smp.mag_y = CORNERS[$urandom_range(4)];
                end
                8, 9: begin
                    smp.mag_x = smp.mag_x + 16'($urandom_range(64) - 32);
                    smp.mag_y = smp.mag_y + 16'($urandom_range(64) - 32);
                end
                default: begin
                    smp.mag_x = 16'($urandom);
                    smp.mag_y = 16'($urandom);
                end
            endcase
            samples.push_back(smp);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (sent < samples.size() || mean_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        @(negedge aclk);
        if (fails == 0 && mean_queue.size() == 0)
            $display("tb_magnetic_heading_moving_average_top: PASS");
        else
            $display("tb_magnetic_heading_moving_average_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mhma_pkg.sv
hdl/magnetic_heading_moving_average_top.sv
tb/tb_magnetic_heading_moving_average_top.sv
